// ===== sv/jtl_pkg.sv =====
// Shared types and constants of the JSON token lexer.
// Used by jtl_ctrl, jtl_dpath and json_token_lexer; depends on nothing.
`default_nettype none
package jtl_pkg;

	localparam int CFG_W          = 64;
	localparam int CFG_IDX_W      = 3;
	localparam int NUM_CFG_REGS   = 8;
	localparam int DEF_KW_SLOTS   = 8;
	localparam int DEF_KW_BYTES   = 8;

	localparam logic [2:0] KIND_END     = 3'd0;
	localparam logic [2:0] KIND_IDENT   = 3'd1;
	localparam logic [2:0] KIND_KEYWORD = 3'd2;
	localparam logic [2:0] KIND_STRING  = 3'd3;
	localparam logic [2:0] KIND_INT     = 3'd4;
	localparam logic [2:0] KIND_REAL    = 3'd5;
	localparam logic [2:0] KIND_SINGLE  = 3'd6;

	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_LOW_E = 8'h65;
	localparam logic [7:0] CH_UP_E  = 8'h45;
	localparam logic [7:0] CH_LOW_U = 8'h75;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       at_end;
	} req_t;

	typedef struct packed {
		logic        event_res;
		logic [15:0] text_unit;
		logic [2:0]  token_kind;
		logic [2:0]  keyword_index;
		logic [7:0]  single_char;
		logic        last;
	} res_t;

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_STR, M_ESC, M_UNI, M_MINUS,
		M_ZERO, M_INT, M_FRAC, M_EXPE, M_EXPS, M_EXPD
	} mode_t;

	typedef enum logic [1:0] {
		PH_WAIT, PH_RUN, PH_FLUSH
	} phase_t;

	typedef enum logic [2:0] {
		U_V, U_ESC, U_UNI, U_UNI_NX, U_H0, U_H1
	} unit_sel_t;

	// classes of the value under work and lexer state; the byte classes are low on the end mark, eof is high
	typedef struct packed {
		logic eof;
		logic digit;
		logic zero;
		logic alpha_start;
		logic ident;
		logic space;
		logic quote;
		logic bslash;
		logic minus;
		logic dot;
		logic exp_e;
		logic sign;
		logic esc_u;
		logic hex_ok;
		logic hex_last;
		logic kw_match;
		logic is_real;
		logic last_val;
		logic pend_v;
		logic slot_free;
	} status_t;

	typedef struct packed {
		logic       take;
		logic       emit;
		logic       is_end;
		unit_sel_t  usel;
		logic [2:0] kind;
		logic       sc_minus;
		logic       ident_start;
		logic       ident_add;
		logic       uni_clr;
		logic       uni_add;
		logic       real_clr;
		logic       real_set;
		logic       hold0;
		logic       hold1;
		logic       held_clr;
		logic       rollback;
		logic       advance;
		logic       flush;
	} cmd_t;

endpackage
`default_nettype wire

// ===== sv/jtl_ctrl.sv =====
// Lexer controller: request phase, lexer mode and emission sub-steps.
// Depends on jtl_pkg; drives jtl_dpath through cmd_t and reads status_t.
`default_nettype none
module jtl_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_ready,
	input  jtl_pkg::status_t st,
	output jtl_pkg::cmd_t    cmd
);
	import jtl_pkg::*;

	phase_t     phase_q, phase_d;
	mode_t      mode_q, mode_d, mode_n;
	logic [1:0] sub_q, sub_d, sub_n;
	cmd_t       a;
	logic       go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			mode_q  <= M_IDLE;
			sub_q   <= 2'd0;
		end else begin
			phase_q <= phase_d;
			mode_q  <= mode_d;
			sub_q   <= sub_d;
		end
	end

	// one step of the lexer on the current value
	always_comb begin
		a      = '0;
		mode_n = mode_q;
		sub_n  = sub_q;
		unique case (mode_q)
			M_IDLE: begin
				if (st.eof) begin
					a.emit = 1'b1; a.is_end = 1'b1; a.kind = KIND_END; a.advance = 1'b1;
				end else if (st.space) begin
					a.advance = 1'b1;
				end else if (st.alpha_start) begin
					a.ident_start = 1'b1; a.emit = 1'b1; a.usel = U_V;
					mode_n = M_IDENT; a.advance = 1'b1;
				end else if (st.quote) begin
					mode_n = M_STR; a.advance = 1'b1;
				end else if (st.digit) begin
					a.real_clr = 1'b1; a.emit = 1'b1; a.usel = U_V;
					mode_n = st.zero ? M_ZERO : M_INT; a.advance = 1'b1;
				end else if (st.minus) begin
					a.real_clr = 1'b1; a.emit = 1'b1; a.usel = U_V;
					mode_n = M_MINUS; a.advance = 1'b1;
				end else if (sub_q == 2'd0) begin
					a.emit = 1'b1; a.usel = U_V; sub_n = 2'd1;
				end else begin
					a.emit = 1'b1; a.is_end = 1'b1; a.kind = KIND_SINGLE;
					sub_n = 2'd0; a.advance = 1'b1;
				end
			end
			M_IDENT: begin
				if (st.ident) begin
					a.ident_add = 1'b1; a.emit = 1'b1; a.usel = U_V; a.advance = 1'b1;
				end else begin
					a.emit = 1'b1; a.is_end = 1'b1;
					a.kind = st.kw_match ? KIND_KEYWORD : KIND_IDENT;
					mode_n = M_IDLE;
				end
			end
			M_STR: begin
				if (st.eof) begin
					mode_n = M_IDLE;
				end else if (st.quote) begin
					a.emit = 1'b1; a.is_end = 1'b1; a.kind = KIND_STRING;
					mode_n = M_IDLE; a.advance = 1'b1;
				end else if (st.bslash) begin
					mode_n = M_ESC; a.advance = 1'b1;
				end else begin
					a.emit = 1'b1; a.usel = U_V; a.advance = 1'b1;
				end
			end
			M_ESC: begin
				if (st.eof) begin
					mode_n = M_IDLE;
				end else if (st.esc_u) begin
					a.uni_clr = 1'b1; mode_n = M_UNI; a.advance = 1'b1;
				end else begin
					a.emit = 1'b1; a.usel = U_ESC; mode_n = M_STR; a.advance = 1'b1;
				end
			end
			M_UNI: begin
				if (st.hex_ok) begin
					a.uni_add = 1'b1; a.advance = 1'b1;
					if (st.hex_last) begin
						a.emit = 1'b1; a.usel = U_UNI_NX; mode_n = M_STR;
					end
				end else begin
					// unit ends early, then lex the byte as string content
					a.emit = 1'b1; a.usel = U_UNI; mode_n = M_STR;
				end
			end
			M_MINUS: begin
				if (st.digit) begin
					a.emit = 1'b1; a.usel = U_V; a.advance = 1'b1;
					mode_n = st.zero ? M_ZERO : M_INT;
				end else begin
					a.emit = 1'b1; a.is_end = 1'b1; a.kind = KIND_SINGLE;
					a.sc_minus = 1'b1; mode_n = M_IDLE;
				end
			end
			M_INT: begin
				if (st.digit) begin
					a.emit = 1'b1; a.usel = U_V; a.advance = 1'b1;
				end else begin
					mode_n = M_ZERO;
				end
			end
			M_ZERO, M_FRAC: begin
				if (mode_q == M_ZERO && st.dot) begin
					a.emit = 1'b1; a.usel = U_V; a.real_set = 1'b1;
					mode_n = M_FRAC; a.advance = 1'b1;
				end else if (mode_q == M_FRAC && st.digit) begin
					a.emit = 1'b1; a.usel = U_V; a.advance = 1'b1;
				end else if (st.exp_e) begin
					a.hold0 = 1'b1; mode_n = M_EXPE; a.advance = 1'b1;
				end else begin
					a.emit = 1'b1; a.is_end = 1'b1;
					a.kind = st.is_real ? KIND_REAL : KIND_INT; mode_n = M_IDLE;
				end
			end
			M_EXPE, M_EXPS: begin
				if (st.digit) begin
					a.emit = 1'b1;
					unique case (sub_q)
						2'd0: begin
							a.usel = U_H0;
							sub_n = (mode_q == M_EXPS) ? 2'd1 : 2'd2;
						end
						2'd1: begin
							a.usel = U_H1; sub_n = 2'd2;
						end
						default: begin
							a.usel = U_V; a.real_set = 1'b1; a.held_clr = 1'b1;
							sub_n = 2'd0; mode_n = M_EXPD; a.advance = 1'b1;
						end
					endcase
				end else if (mode_q == M_EXPE && st.sign) begin
					a.hold1 = 1'b1; mode_n = M_EXPS; a.advance = 1'b1;
				end else begin
					// no exponent digit: end the number and replay the held bytes
					a.emit = 1'b1; a.is_end = 1'b1;
					a.kind = st.is_real ? KIND_REAL : KIND_INT;
					mode_n = M_IDLE; a.rollback = 1'b1;
				end
			end
			M_EXPD: begin
				if (st.digit) begin
					a.emit = 1'b1; a.usel = U_V; a.advance = 1'b1;
				end else begin
					a.emit = 1'b1; a.is_end = 1'b1;
					a.kind = st.is_real ? KIND_REAL : KIND_INT; mode_n = M_IDLE;
				end
			end
			default: begin
				mode_n = M_IDLE;
			end
		endcase
	end

	assign go = !(a.emit && st.pend_v && !st.slot_free);

	always_comb begin
		cmd       = '0;
		phase_d   = phase_q;
		mode_d    = mode_q;
		sub_d     = sub_q;
		req_ready = 1'b0;
		unique case (phase_q)
			PH_WAIT: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take = 1'b1;
					phase_d  = PH_RUN;
				end
			end
			PH_RUN: begin
				if (go) begin
					cmd    = a;
					mode_d = mode_n;
					sub_d  = sub_n;
					if (a.advance && st.last_val) phase_d = PH_FLUSH;
				end
			end
			PH_FLUSH: begin
				if (!st.pend_v) begin
					phase_d = PH_WAIT;
				end else if (st.slot_free) begin
					cmd.flush = 1'b1;
					phase_d   = PH_WAIT;
				end
			end
			default: begin
				phase_d = PH_WAIT;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/jtl_dpath.sv =====
// Lexer datapath: value replay, identifier prefix, keyword compare, \u unit,
// pending result and output register. Depends on jtl_pkg; run by jtl_ctrl.
`default_nettype none
module jtl_dpath #(
	parameter int KEYWORD_SLOTS = jtl_pkg::DEF_KW_SLOTS,
	parameter int KEYWORD_BYTES = jtl_pkg::DEF_KW_BYTES
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  jtl_pkg::req_t                     req_data,
	output jtl_pkg::res_t                     res_data,
	output logic                              res_valid,
	input  wire                               res_ready,
	input  wire                               cfg_we,
	input  wire [jtl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [jtl_pkg::CFG_W-1:0]          cfg_data,
	input  jtl_pkg::cmd_t                     cmd,
	output jtl_pkg::status_t                  st
);
	import jtl_pkg::*;

	localparam int CNT_W = $clog2(KEYWORD_BYTES + 2);

	logic [CFG_W-1:0] kw_q [KEYWORD_SLOTS];
	req_t             cur_q;
	logic [7:0]       held_q [2];
	logic [1:0]       held_cnt_q, hc_q, pos_q;
	logic [CFG_W-1:0] prefix_q;
	logic [CNT_W-1:0] icnt_q;
	logic [15:0]      uni_q;
	logic [1:0]       hex_q;
	logic             real_q;
	res_t             pend_q, out_q;
	logic             pend_v_q, out_v_q;

	logic [7:0]  v;
	logic        v_eof, alpha, dig;
	logic [3:0]  hexv;
	logic        hex_ok;
	logic [7:0]  esc;
	logic        kw_hit;
	logic [2:0]  kw_idx;
	logic        slot_free, push;
	res_t        new_res;
	res_t        push_res;

	// replay held bytes first, then the accepted value
	always_comb begin
		if (pos_q < hc_q) begin
			v     = held_q[pos_q[0]];
			v_eof = 1'b0;
		end else begin
			v     = cur_q.in_byte;
			v_eof = cur_q.at_end;
		end
	end

	assign alpha = (v >= 8'h61 && v <= 8'h7A) || (v >= 8'h41 && v <= 8'h5A);
	assign dig   = (v >= 8'h30 && v <= 8'h39);

	always_comb begin
		hex_ok = 1'b1;
		hexv   = 4'd0;
		if (dig) hexv = v[3:0];
		else if (v >= 8'h61 && v <= 8'h66) hexv = 4'(v - 8'h57);
		else if (v >= 8'h41 && v <= 8'h46) hexv = 4'(v - 8'h37);
		else hex_ok = 1'b0;
	end

	always_comb begin
		unique case (v)
			8'h62:   esc = 8'd8;
			8'h66:   esc = 8'd12;
			8'h6E:   esc = 8'd10;
			8'h72:   esc = 8'd13;
			8'h74:   esc = 8'd9;
			default: esc = v;
		endcase
	end

	// lowest matching slot wins
	always_comb begin
		kw_hit = 1'b0;
		kw_idx = 3'd0;
		for (int i = KEYWORD_SLOTS - 1; i >= 0; i--) begin
			if (kw_q[i] != '0 && kw_q[i] == prefix_q) begin
				kw_hit = 1'b1;
				kw_idx = 3'(i);
			end
		end
	end

	always_comb begin
		st             = '0;
		st.eof         = v_eof;
		st.digit       = !v_eof && dig;
		st.zero        = !v_eof && v == CH_ZERO;
		st.alpha_start = !v_eof && (alpha || v == CH_UNDER || v == CH_DOLLAR);
		st.ident       = !v_eof && (alpha || dig || v == CH_UNDER || v == CH_DOLLAR);
		st.space       = !v_eof && (v == 8'h20 || (v >= 8'd9 && v <= 8'd13));
		st.quote       = !v_eof && v == CH_QUOTE;
		st.bslash      = !v_eof && v == CH_BSLASH;
		st.minus       = !v_eof && v == CH_MINUS;
		st.dot         = !v_eof && v == CH_DOT;
		st.exp_e       = !v_eof && (v == CH_LOW_E || v == CH_UP_E);
		st.sign        = !v_eof && (v == CH_PLUS || v == CH_MINUS);
		st.esc_u       = !v_eof && v == CH_LOW_U;
		st.hex_ok      = !v_eof && hex_ok;
		st.hex_last    = hex_q == 2'd3;
		st.kw_match    = kw_hit && icnt_q <= CNT_W'(KEYWORD_BYTES);
		st.is_real     = real_q;
		st.last_val    = pos_q == hc_q;
		st.pend_v      = pend_v_q;
		st.slot_free   = slot_free;
	end

	always_comb begin
		new_res = '0;
		if (cmd.is_end) begin
			new_res.event_res  = 1'b1;
			new_res.token_kind = cmd.kind;
			if (cmd.kind == KIND_KEYWORD) new_res.keyword_index = kw_idx;
			if (cmd.kind == KIND_SINGLE) new_res.single_char = cmd.sc_minus ? CH_MINUS : v;
		end else begin
			unique case (cmd.usel)
				U_V:      new_res.text_unit = {8'h00, v};
				U_ESC:    new_res.text_unit = {8'h00, esc};
				U_UNI:    new_res.text_unit = uni_q;
				U_UNI_NX: new_res.text_unit = {uni_q[11:0], hexv};
				U_H0:     new_res.text_unit = {8'h00, held_q[0]};
				U_H1:     new_res.text_unit = {8'h00, held_q[1]};
				default:  new_res.text_unit = 16'h0000;
			endcase
		end
	end

	// flag last only on the flush of the final pending result
	always_comb begin
		push_res      = pend_q;
		push_res.last = cmd.flush;
	end

	assign slot_free = !out_v_q || res_ready;
	assign push      = pend_v_q && (cmd.emit || cmd.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEYWORD_SLOTS; i++) kw_q[i] <= '0;
			held_cnt_q <= 2'd0;
			hc_q       <= 2'd0;
			pos_q      <= 2'd0;
			icnt_q     <= '0;
			hex_q      <= 2'd0;
			real_q     <= 1'b0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			for (int i = 0; i < KEYWORD_SLOTS; i++) begin
				if (cfg_we && cfg_index == CFG_IDX_W'(i)) kw_q[i] <= cfg_data;
			end
			if (cmd.take) begin
				pos_q <= 2'd0;
				hc_q  <= 2'd0;
			end else if (cmd.rollback) begin
				pos_q      <= 2'd0;
				hc_q       <= held_cnt_q;
				held_cnt_q <= 2'd0;
			end else if (cmd.advance) begin
				pos_q <= pos_q + 2'd1;
			end
			if (cmd.hold0) held_cnt_q <= 2'd1;
			if (cmd.hold1) held_cnt_q <= 2'd2;
			if (cmd.held_clr) held_cnt_q <= 2'd0;
			if (cmd.ident_start) icnt_q <= CNT_W'(1);
			else if (cmd.ident_add && icnt_q <= CNT_W'(KEYWORD_BYTES)) icnt_q <= icnt_q + 1'b1;
			if (cmd.uni_clr) hex_q <= 2'd0;
			else if (cmd.uni_add) hex_q <= hex_q + 2'd1;
			if (cmd.real_clr) real_q <= 1'b0;
			else if (cmd.real_set) real_q <= 1'b1;
			if (cmd.emit) pend_v_q <= 1'b1;
			else if (cmd.flush) pend_v_q <= 1'b0;
			if (push) out_v_q <= 1'b1;
			else if (res_ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) cur_q <= req_data;
		if (cmd.hold0) held_q[0] <= v;
		if (cmd.hold1) held_q[1] <= v;
		if (cmd.ident_start) begin
			prefix_q <= {{(CFG_W-8){1'b0}}, v};
		end else if (cmd.ident_add) begin
			for (int k = 0; k < KEYWORD_BYTES; k++) begin
				if (icnt_q == CNT_W'(k)) prefix_q[8*k +: 8] <= v;
			end
		end
		if (cmd.uni_clr) uni_q <= 16'h0000;
		else if (cmd.uni_add) uni_q <= {uni_q[11:0], hexv};
		if (cmd.emit) pend_q <= new_res;
		if (push) out_q <= push_res;
	end

	assign res_data  = out_q;
	assign res_valid = out_v_q;

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n) push |-> slot_free)
		else $error("pending result moved into a full output register");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= hc_q + 2'd1 && hc_q <= 2'd2 && held_cnt_q <= 2'd2)
		else $error("replay position out of range");
	a_flush_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> !pend_v_q && out_v_q && out_q.last)
		else $error("final result not delivered with last");
	a_take_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> !pend_v_q)
		else $error("new request taken with a result still pending");
`endif

endmodule
`default_nettype wire

// ===== sv/json_token_lexer.sv =====
// Top level of the JSON token lexer: joins controller and datapath.
// Depends on jtl_pkg, jtl_ctrl and jtl_dpath.
//
// One request carries a source byte or an end mark; it yields zero to seven
// results (text code units and token-end events), the final one flagged last.
// The controller does one lexer step per cycle, but output backpressure
// stalls the step that needs the output register; each step moves at most
// one result into a one-deep pending register before the output register.
// A request is accepted, then lexed in steps (a byte that ends a token
// without being part of it is stepped again, and up to two held bytes are
// replayed when an exponent is dropped); its last result is then output.
// Keyword registers are written via cfg_we/cfg_index/cfg_data. The user
// must write them only while idle; the block itself does not enforce it.
`default_nettype none
module json_token_lexer #(
	parameter int KEYWORD_SLOTS = jtl_pkg::DEF_KW_SLOTS,
	parameter int KEYWORD_BYTES = jtl_pkg::DEF_KW_BYTES
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          req_valid,
	output logic                         req_ready,
	input  jtl_pkg::req_t                req_data,
	output logic                         res_valid,
	input  wire                          res_ready,
	output jtl_pkg::res_t                res_data,
	input  wire                          cfg_we,
	input  wire [jtl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [jtl_pkg::CFG_W-1:0]     cfg_data
);
	import jtl_pkg::*;

	cmd_t    cmd;
	status_t st;

	jtl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.st        (st),
		.cmd       (cmd)
	);

	jtl_dpath #(
		.KEYWORD_SLOTS (KEYWORD_SLOTS),
		.KEYWORD_BYTES (KEYWORD_BYTES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.res_data  (res_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st)
	);

endmodule
`default_nettype wire
